// ----- hdl/swmf_pkg.sv -----
`default_nettype none

package swmf_pkg;

    // Width of the window setting register and its value after reset.
    localparam int SET_W = 4;
    localparam logic [SET_W-1:0] SETTING_RESET = 4'd5;

    // Half window is the setting divided by two, so it never exceeds seven.
    localparam int HALF_W = SET_W - 1;

    // Longest window that the setting can ask for, and the width of a length or rank.
    localparam int MAX_LEN = 2 * ((2 ** SET_W - 1) / 2) + 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Per-scan sample count, saturating.
    localparam int SEEN_W     = 5;
    localparam int SEEN_LIMIT = 2 ** SEEN_W - 1;

    // Control from the sequencer to the rank unit.
    typedef struct packed {
        logic clear;
        logic load;
    } rank_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/swmf_sample_mem.sv -----
`default_nettype none

module swmf_sample_mem #(
    parameter int DEPTH = 15,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     rd_valid
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Marks the cycle in which read data is present.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/swmf_rank_unit.sv -----
`default_nettype none

module swmf_rank_unit #(
    parameter int RANGE_BITS = 16,
    parameter int CELLS      = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  swmf_pkg::rank_ctl_t         ctl,
    input  logic [RANGE_BITS-1:0]       load_value,
    input  logic [swmf_pkg::LEN_W-1:0]  median_rank,
    output logic [RANGE_BITS-1:0]       median
);

    import swmf_pkg::*;

    localparam int CIW = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [RANGE_BITS-1:0] val_reg  [CELLS];
    logic [LEN_W-1:0]      rank_reg [CELLS];
    logic [LEN_W-1:0]      fill_reg;
    logic [LEN_W-1:0]      fill_next;
    logic [CELLS-1:0]      occupied;
    logic [CELLS-1:0]      above;
    logic [LEN_W-1:0]      new_rank;
    logic [CIW-1:0]        fill_idx;

    assign fill_idx = fill_reg[CIW-1:0];

    // Compare the incoming sample with every filled cell. Equal earlier
    // samples count as smaller, so the ranks always form a permutation.
    always_comb
    begin
        new_rank = '0;
        for (int c = 0; c < CELLS; c++)
        begin
            occupied[c] = (LEN_W'(c) < fill_reg);
            above[c]    = occupied[c] && (val_reg[c] > load_value);
            if (occupied[c] && !above[c])
            begin
                new_rank = new_rank + LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            fill_next = '0;
        end
        else if (ctl.load)
        begin
            fill_next = fill_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Cell contents: larger cells move up one rank, the new sample takes its own.
    always_ff @(posedge clk)
    begin
        if (ctl.load && !ctl.clear)
        begin
            for (int c = 0; c < CELLS; c++)
            begin
                if (above[c])
                begin
                    rank_reg[c] <= rank_reg[c] + LEN_W'(1);
                end
            end
            val_reg[fill_idx]  <= load_value;
            rank_reg[fill_idx] <= new_rank;
        end
    end

    // Exactly one filled cell holds the requested rank.
    always_comb
    begin
        median = '0;
        for (int c = 0; c < CELLS; c++)
        begin
            if (occupied[c] && (rank_reg[c] == median_rank))
            begin
                median = median | val_reg[c];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sliding_window_median_filter.sv -----
// Running median filter over one scan of range samples; L is the clipped window length.
// A sample that releases a result is accepted; then the ranks are cleared, the L window
// samples are read and ranked, and the median is selected. No sample is taken meanwhile,
// and a sample that releases no result leaves the block idle, ready for the next one.
// A flushing last sample repeats these steps for each result; output stalls hold the select.
// Reset clears the control state and sets the window setting to 5; samples are not cleared.
`default_nettype none

module sliding_window_median_filter #(
    parameter int MAX_WINDOW = 15,
    parameter int RANGE_BITS = 16,
    localparam int TDATA_W   = ((RANGE_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [swmf_pkg::SET_W-1:0] cfg_wr_data,  // window_setting
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [TDATA_W-1:0]         s_tdata,      // range_sample
    input  logic                       s_tlast,      // scan_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [TDATA_W-1:0]         m_tdata,      // filtered_range
    output logic                       m_tlast       // scan_end
);

    import swmf_pkg::*;

    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int HALF_CAP = (MAX_WINDOW - 1) / 2;
    localparam int CELLS    = (MAX_WINDOW < MAX_LEN) ? MAX_WINDOW : MAX_LEN;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD,
        ST_SELECT
    } state_t;

    state_t                state_reg,     state_next;
    logic [SET_W-1:0]      setting_reg,   setting_next;
    logic [AW-1:0]         wptr_reg,      wptr_next;
    logic [AW-1:0]         rptr_reg,      rptr_next;
    logic [SEEN_W-1:0]     seen_reg,      seen_next;
    logic [SEEN_W-1:0]     seen_cap_reg,  seen_cap_next;
    logic [HALF_W-1:0]     half_reg,      half_next;
    logic                  last_reg,      last_next;
    logic [HALF_W-1:0]     j_reg,         j_next;
    logic [LEN_W-1:0]      len_reg,       len_next;
    logic [LEN_W-1:0]      issue_reg,     issue_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RANGE_BITS-1:0] out_data_reg,  out_data_next;
    logic                  out_end_reg,   out_end_next;

    logic [HALF_W-1:0]     half_raw;
    logic [HALF_W-1:0]     half_now;
    logic                  seen_short;
    logic [HALF_W-1:0]     jmax;
    logic                  s_accept;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [RANGE_BITS-1:0] rd_data;
    logic                  rd_valid;
    logic [SEEN_W-1:0]     span_sum;
    logic [SEEN_W-1:0]     span;
    logic [LEN_W-1:0]      len_calc;
    logic                  out_free;
    logic [RANGE_BITS-1:0] median;
    rank_ctl_t             rank_ctl;

    // Half window from the setting, capped so the window fits the store.
    assign half_raw   = setting_reg[SET_W-1:1];
    assign half_now   = (int'(half_raw) > HALF_CAP) ? HALF_W'(HALF_CAP) : half_raw;
    assign seen_short = (seen_reg < SEEN_W'(half_now));
    assign jmax       = seen_short ? HALF_W'(seen_reg) : half_now;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Circular write pointer; the newest sample sits at wptr_reg.
    assign wr_addr = (wptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : wptr_reg + AW'(1);
    assign rd_en   = (state_reg == ST_LOAD) && (issue_reg != len_reg);

    // Window length for the current result, clipped at the scan start.
    assign span_sum = SEEN_W'(j_reg) + SEEN_W'(half_reg);
    assign span     = (span_sum > seen_cap_reg) ? seen_cap_reg : span_sum;
    assign len_calc = LEN_W'(span) + LEN_W'(1);

    assign rank_ctl.clear = (state_reg == ST_START);
    assign rank_ctl.load  = rd_valid;

    assign out_free = !out_valid_reg || m_tready;

    swmf_sample_mem #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (RANGE_BITS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s_accept),
        .wr_addr  (wr_addr),
        .wr_data  (s_tdata[RANGE_BITS-1:0]),
        .rd_en    (rd_en),
        .rd_addr  (rptr_reg),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    swmf_rank_unit #(
        .RANGE_BITS (RANGE_BITS),
        .CELLS      (CELLS)
    ) u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (rank_ctl),
        .load_value  (rd_data),
        .median_rank (len_reg >> 1),
        .median      (median)
    );

    // Sequencer: one result at a time, reading its window newest first.
    always_comb
    begin
        state_next     = state_reg;
        setting_next   = setting_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        seen_next      = seen_reg;
        seen_cap_next  = seen_cap_reg;
        half_next      = half_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        len_next       = len_reg;
        issue_next     = issue_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_end_next   = out_end_reg;

        if (cfg_wr_en)
        begin
            setting_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    wptr_next     = wr_addr;
                    seen_cap_next = seen_reg;
                    half_next     = half_now;
                    last_next     = s_tlast;
                    if (s_tlast)
                    begin
                        j_next     = jmax;
                        seen_next  = '0;
                        state_next = ST_START;
                    end
                    else
                    begin
                        j_next    = half_now;
                        seen_next = (seen_reg == SEEN_W'(SEEN_LIMIT)) ?
                                    seen_reg : seen_reg + SEEN_W'(1);
                        if (!seen_short)
                        begin
                            state_next = ST_START;
                        end
                    end
                end
            end
            ST_START:
            begin
                len_next   = len_calc;
                issue_next = '0;
                rptr_next  = wptr_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + LEN_W'(1);
                    rptr_next  = (rptr_reg == '0) ? AW'(MAX_WINDOW - 1) : rptr_reg - AW'(1);
                end
                if ((issue_reg == len_reg) && !rd_valid)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = median;
                    out_end_next   = last_reg && (j_reg == '0);
                    if (last_reg && (j_reg != '0))
                    begin
                        j_next     = j_reg - HALF_W'(1);
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            setting_reg   <= SETTING_RESET;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            seen_reg      <= '0;
            seen_cap_reg  <= '0;
            half_reg      <= '0;
            last_reg      <= 1'b0;
            j_reg         <= '0;
            len_reg       <= '0;
            issue_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            setting_reg   <= setting_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            seen_reg      <= seen_next;
            seen_cap_reg  <= seen_cap_next;
            half_reg      <= half_next;
            last_reg      <= last_next;
            j_reg         <= j_next;
            len_reg       <= len_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_end_reg   <= out_end_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);
    assign m_tlast  = out_end_reg;

endmodule

`default_nettype wire

// ----- hdl/swmf_checker.sv -----
`default_nettype none

module swmf_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    // A result stays offered until its transfer completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before transfer");

    // The end-of-scan flag holds while a result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tlast))
    else $error("scan end flag changed while stalled");

    // A new result only appears while the block is busy with a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while input side was idle");

    // No result can be produced in the cycle right after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared directly after input transfer");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

`default_nettype wire
